// ===== rtl/dvbs2_plheader_diff_correlator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DVBS2_PLHEADER_DIFF_CORRELATOR_ASSERT_SVH
`define DVBS2_PLHEADER_DIFF_CORRELATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpc assertion failed");

`endif

// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Constants, tap table and types of the PL header differential correlator.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int SOF_LENGTH      = 26;
    localparam int PLS_LENGTH      = 64;
    localparam int WIN_LEN         = SOF_LENGTH + PLS_LENGTH;
    localparam int SOF_TAPS        = SOF_LENGTH - 1;
    localparam int NUM_TAPS        = SOF_LENGTH - 1 + PLS_LENGTH / 2;
    localparam int TAP_W           = $clog2(NUM_TAPS + 1);
    localparam int POS_W           = $clog2(WIN_LEN + 1);
    localparam int CORR_W          = 30;
    localparam int THRESH_W        = 59;
    localparam int MAG_W           = 2 * CORR_W;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam logic [SOF_LENGTH-1:0] SOF_WORD = 26'h18D2E82;
    localparam logic [PLS_LENGTH-1:0] PLS_WORD = 64'h719D83C953422DFA;
    localparam logic [SOF_LENGTH-1:0] DSOF     = SOF_WORD ^ (SOF_WORD >> 1);
    localparam logic [PLS_LENGTH-1:0] DPLS     = PLS_WORD ^ (PLS_WORD >> 1);

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             pls;
        logic             add;
    } tap_t;

    function automatic tap_t tap_info(input logic [TAP_W-1:0] k);
        tap_t t;
        int   i;
        t = '0;
        if (int'(k) < SOF_TAPS)
        begin
            i     = int'(k) + 1;
            t.pos = POS_W'(i);
            t.pls = 1'b0;
            t.add = DSOF[SOF_LENGTH-1-i] ^ i[0];
        end
        else if (int'(k) < NUM_TAPS)
        begin
            i     = 2 * (int'(k) - SOF_TAPS) + 1;
            t.pos = POS_W'(SOF_LENGTH + i);
            t.pls = 1'b1;
            t.add = ~DPLS[PLS_LENGTH-1-i];
        end
        return t;
    endfunction

endpackage

// ===== rtl/dvbs2_plheader_diff_correlator.sv =====
// ----------------------------------------------------------------------------
// dvbs2_plheader_diff_correlator
// Differential correlator for the DVB-S2 PL header (SOF and PLS code).
// ----------------------------------------------------------------------------
// One beat on the input channel carries one complex symbol; each symbol gives
// one beat on the output channel with the chosen correlation, the pilots
// flag, the header hit flag and the window status.
// The front forms the differential product in the cycle of acceptance and
// places it in a two-entry queue. The back writes it to a 90-entry ring RAM
// and reads the 57 correlation taps one per cycle through the single read
// port, then saturates, squares and compares in the states SAT, MAG and CMP.
// The back pops a new product only when it is idle, so it finishes one
// symbol before it takes the next; the output beat is registered.
// The threshold register may be written whenever the block is idle.
// Reset clears the previous symbol, the fill count and the threshold; the
// ring contents are not cleared, as positions not yet filled read as zero.
// A stalled output beat holds; the queue lets the front take two more
// symbols before it raises in_stall.
// ----------------------------------------------------------------------------
module dvbs2_plheader_diff_correlator import dpc_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [THRESH_W-1:0]           cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [CORR_W-1:0]      corr_re,
    output logic signed [CORR_W-1:0]      corr_im,
    output logic                          header_hit,
    output logic                          pilots_on,
    output logic                          window_full
);

    localparam int PROD_W = 2 * SAMPLE_BITS + 1;

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    logic [2*PROD_W-1:0] push_data;
    logic [2*PROD_W-1:0] pop_data;

    assign in_stall = q_full;

    dpc_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .PROD_W     (PROD_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .q_full   (q_full),
        .sample_i (sample_i),
        .sample_q (sample_q),
        .push     (push),
        .push_data(push_data)
    );

    dpc_queue #(
        .WIDTH(2 * PROD_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .pop_data (pop_data)
    );

    dpc_back #(
        .PROD_W(PROD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .corr_re    (corr_re),
        .corr_im    (corr_im),
        .header_hit (header_hit),
        .pilots_on  (pilots_on),
        .window_full(window_full)
    );

endmodule

// ===== rtl/dpc_ram.sv =====
// ----------------------------------------------------------------------------
// dpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/dpc_front.sv =====
// ----------------------------------------------------------------------------
// dpc_front
// Accepts symbols and forms the differential product with the previous one.
// ----------------------------------------------------------------------------
module dpc_front import dpc_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int PROD_W      = 2 * SAMPLE_BITS + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          q_full,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    output logic                          push,
    output logic [2*PROD_W-1:0]           push_data
);

    logic signed [SAMPLE_BITS-1:0] prev_i_reg;
    logic signed [SAMPLE_BITS-1:0] prev_q_reg;
    logic signed [PROD_W-1:0]      a;
    logic signed [PROD_W-1:0]      b;
    logic signed [PROD_W-1:0]      c;
    logic signed [PROD_W-1:0]      d;
    logic signed [PROD_W-1:0]      prod_re;
    logic signed [PROD_W-1:0]      prod_im;

    assign push = in_valid && !q_full;
    assign a = PROD_W'(sample_i);
    assign b = PROD_W'(sample_q);
    assign c = PROD_W'(prev_i_reg);
    assign d = PROD_W'(prev_q_reg);
    assign prod_re = a * c + b * d;
    assign prod_im = b * c - a * d;
    assign push_data = {prod_re, prod_im};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end
        else if (push)
        begin
            prev_i_reg <= sample_i;
            prev_q_reg <= sample_q;
        end
    end

endmodule

// ===== rtl/dpc_queue.sv =====
// ----------------------------------------------------------------------------
// dpc_queue
// Two-entry queue of differential products between front and back.
// ----------------------------------------------------------------------------
module dpc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

endmodule

// ===== rtl/dpc_back.sv =====
// ----------------------------------------------------------------------------
// dpc_back
// Stores products in a ring, correlates the header taps one per cycle and
// chooses the stronger combination.
// ----------------------------------------------------------------------------
module dpc_back import dpc_pkg::*; #(
    parameter int PROD_W = 2 * DEF_SAMPLE_BITS + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [THRESH_W-1:0]      cfg_wr_data,
    input  logic                     q_empty,
    input  logic [2*PROD_W-1:0]      q_data,
    output logic                     pop,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [CORR_W-1:0] corr_re,
    output logic signed [CORR_W-1:0] corr_im,
    output logic                     header_hit,
    output logic                     pilots_on,
    output logic                     window_full
);

    localparam int SUM_W  = (PROD_W + 8 > CORR_W + 1) ? PROD_W + 8 : CORR_W + 1;
    localparam int ACC_W  = SUM_W - 1;
    localparam int ADDR_W = $clog2(WIN_LEN);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [THRESH_W-1:0]      thr_reg;
    logic [ADDR_W-1:0]        wptr_reg;
    logic [POS_W-1:0]         fill_reg;
    logic [TAP_W-1:0]         cnt_reg;
    logic                     rd_vld_reg;
    logic                     rd_pls_reg;
    logic                     rd_add_reg;
    logic                     rd_zero_reg;
    logic signed [ACC_W-1:0]  sre_reg;
    logic signed [ACC_W-1:0]  sim_reg;
    logic signed [ACC_W-1:0]  pre_reg;
    logic signed [ACC_W-1:0]  pim_reg;
    logic signed [CORR_W-1:0] c0re_reg;
    logic signed [CORR_W-1:0] c0im_reg;
    logic signed [CORR_W-1:0] c1re_reg;
    logic signed [CORR_W-1:0] c1im_reg;
    logic [MAG_W-1:0]         q0re_reg;
    logic [MAG_W-1:0]         q0im_reg;
    logic [MAG_W-1:0]         q1re_reg;
    logic [MAG_W-1:0]         q1im_reg;
    logic                     out_vld_reg;
    logic signed [CORR_W-1:0] ore_reg;
    logic signed [CORR_W-1:0] oim_reg;
    logic                     hit_reg;
    logic                     pil_reg;
    logic                     full_reg;

    tap_t                     tap;
    logic [POS_W:0]           addr_sum;
    logic [ADDR_W-1:0]        rd_addr;
    logic [2*PROD_W-1:0]      rd_data;
    logic signed [ACC_W-1:0]  term_re;
    logic signed [ACC_W-1:0]  term_im;
    logic                     wr_en;
    logic [MAG_W-1:0]         m0;
    logic [MAG_W-1:0]         m1;
    logic [MAG_W-1:0]         msel;
    logic                     pick1;
    logic signed [CORR_W-1:0] sel_re;
    logic signed [CORR_W-1:0] sel_im;
    logic                     load_out;
    logic signed [MAG_W-1:0]  sq0re;
    logic signed [MAG_W-1:0]  sq0im;
    logic signed [MAG_W-1:0]  sq1re;
    logic signed [MAG_W-1:0]  sq1im;

    function automatic logic signed [CORR_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:CORR_W-1] == {(SUM_W-CORR_W+1){1'b0}})
            || (v[SUM_W-1:CORR_W-1] == {(SUM_W-CORR_W+1){1'b1}});
        if (fits)
        begin
            return v[CORR_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            return {1'b1, {(CORR_W-1){1'b0}}};
        end
        return {1'b0, {(CORR_W-1){1'b1}}};
    endfunction

    assign pop   = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en = pop;
    assign tap   = tap_info(cnt_reg);

    always_comb
    begin
        addr_sum = (POS_W + 1)'(wptr_reg) + (POS_W + 1)'(tap.pos);
        if (addr_sum >= (POS_W + 1)'(WIN_LEN))
        begin
            addr_sum = addr_sum - (POS_W + 1)'(WIN_LEN);
        end
        rd_addr = addr_sum[ADDR_W-1:0];
    end

    dpc_ram #(
        .WIDTH(2 * PROD_W),
        .DEPTH(WIN_LEN)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wptr_reg),
        .wr_data(q_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign term_re = rd_zero_reg ? '0 : ACC_W'($signed(rd_data[2*PROD_W-1:PROD_W]));
    assign term_im = rd_zero_reg ? '0 : ACC_W'($signed(rd_data[PROD_W-1:0]));

    assign sq0re = c0re_reg * c0re_reg;
    assign sq0im = c0im_reg * c0im_reg;
    assign sq1re = c1re_reg * c1re_reg;
    assign sq1im = c1im_reg * c1im_reg;

    assign m0     = q0re_reg + q0im_reg;
    assign m1     = q1re_reg + q1im_reg;
    assign pick1  = !(m0 > m1);
    assign sel_re = pick1 ? c1re_reg : c0re_reg;
    assign sel_im = pick1 ? c1im_reg : c0im_reg;
    assign msel   = pick1 ? m1 : m0;
    assign load_out = (state_reg == ST_CMP) && (!out_vld_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == TAP_W'(NUM_TAPS))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_pls_reg  <= tap.pls;
        rd_add_reg  <= tap.add;
        rd_zero_reg <= tap.pos < (POS_W'(WIN_LEN) - fill_reg);
        if (pop)
        begin
            sre_reg <= '0;
            sim_reg <= '0;
            pre_reg <= '0;
            pim_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_pls_reg)
            begin
                pre_reg <= rd_add_reg ? pre_reg + term_re : pre_reg - term_re;
                pim_reg <= rd_add_reg ? pim_reg + term_im : pim_reg - term_im;
            end
            else
            begin
                sre_reg <= rd_add_reg ? sre_reg + term_re : sre_reg - term_re;
                sim_reg <= rd_add_reg ? sim_reg + term_im : sim_reg - term_im;
            end
        end
        if (state_reg == ST_SAT)
        begin
            c0re_reg <= sat(SUM_W'(sre_reg) + SUM_W'(pre_reg));
            c0im_reg <= sat(SUM_W'(sim_reg) + SUM_W'(pim_reg));
            c1re_reg <= sat(SUM_W'(sre_reg) - SUM_W'(pre_reg));
            c1im_reg <= sat(SUM_W'(sim_reg) - SUM_W'(pim_reg));
        end
        if (state_reg == ST_MAG)
        begin
            q0re_reg <= sq0re;
            q0im_reg <= sq0im;
            q1re_reg <= sq1re;
            q1im_reg <= sq1im;
        end
        if (load_out)
        begin
            ore_reg  <= sel_re;
            oim_reg  <= sel_im;
            pil_reg  <= pick1;
            hit_reg  <= (msel > MAG_W'(thr_reg)) && !sel_im[CORR_W-1] && (sel_im != '0);
            full_reg <= (fill_reg == POS_W'(WIN_LEN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            wptr_reg    <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_READ) && (cnt_reg != TAP_W'(NUM_TAPS));
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                wptr_reg <= (wptr_reg == ADDR_W'(WIN_LEN - 1)) ? '0 : wptr_reg + 1'b1;
                if (fill_reg != POS_W'(WIN_LEN))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                cnt_reg <= '0;
            end
            else if (state_reg == ST_READ && cnt_reg != TAP_W'(NUM_TAPS))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_vld_reg;
    assign corr_re     = ore_reg;
    assign corr_im     = oim_reg;
    assign header_hit  = hit_reg;
    assign pilots_on   = pil_reg;
    assign window_full = full_reg;

endmodule

// ===== rtl/dpc_checker.sv =====
// ----------------------------------------------------------------------------
// dpc_checker
// Port-level checks of the correlator, bound to the top level.
// ----------------------------------------------------------------------------
`include "dvbs2_plheader_diff_correlator_assert.svh"

module dpc_checker import dpc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CORR_W-1:0] corr_im,
    input logic              header_hit,
    input logic              window_full
);

    `DPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `DPC_ASSERT_NOW(a_hit_im_pos, out_valid && header_hit, !corr_im[CORR_W-1] && corr_im != '0)
    `DPC_ASSERT_NEXT(a_full_sticky, out_valid && window_full, !out_valid || window_full)

endmodule

bind dvbs2_plheader_diff_correlator dpc_checker u_dpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .corr_im    (corr_im),
    .header_hit (header_hit),
    .window_full(window_full)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PL header differential correlator.
// ----------------------------------------------------------------------------
// Symbols are driven with random gaps and the output is stalled at random,
// including one long hold-off that fills the block. A behavioural model of
// the window correlation predicts every output beat, and a scoreboard checks
// the beats field by field. The threshold is changed between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import dpc_pkg::*;

    typedef struct {
        logic signed [CORR_W-1:0] re;
        logic signed [CORR_W-1:0] im;
        logic                     hit;
        logic                     pilots;
        logic                     full;
    } corr_beat_t;

    class corr_scoreboard;
        corr_beat_t pending[$];
        int         errors;
        longint     prev_re, prev_im;
        longint     win_re[WIN_LEN];
        longint     win_im[WIN_LEN];
        int         fill;
        logic [THRESH_W-1:0] thresh;
        int         beats_checked;
        int         hits_seen;
        int         pilots_seen;

        function new();
            errors = 0;
            prev_re = 0;
            prev_im = 0;
            fill = 0;
            thresh = '0;
            beats_checked = 0;
            hits_seen = 0;
            pilots_seen = 0;
            foreach (win_re[k])
            begin
                win_re[k] = 0;
                win_im[k] = 0;
            end
        endfunction

        function longint clip(longint v);
            if (v > 536870911)
                return 536870911;
            if (v < -536870912)
                return -536870912;
            return v;
        endfunction

        function void note_symbol(logic signed [11:0] si, logic signed [11:0] sq);
            longint a, b, sre, sim, pre, pim, r0, i0, r1, i1, m0, m1;
            corr_beat_t e;
            logic [SOF_LENGTH-1:0] dsof;
            logic [PLS_LENGTH-1:0] dpls;
            dsof = SOF_WORD ^ (SOF_WORD >> 1);
            dpls = PLS_WORD ^ (PLS_WORD >> 1);
            a = si;
            b = sq;
            for (int k = 0; k < WIN_LEN - 1; k++)
            begin
                win_re[k] = win_re[k+1];
                win_im[k] = win_im[k+1];
            end
            win_re[WIN_LEN-1] = a * prev_re + b * prev_im;
            win_im[WIN_LEN-1] = b * prev_re - a * prev_im;
            prev_re = a;
            prev_im = b;
            if (fill < WIN_LEN)
                fill++;
            sre = 0; sim = 0; pre = 0; pim = 0;
            for (int k = 1; k < SOF_LENGTH; k++)
            begin
                if (dsof[SOF_LENGTH-1-k] ^ k[0])
                begin
                    sre += win_re[k];
                    sim += win_im[k];
                end
                else
                begin
                    sre -= win_re[k];
                    sim -= win_im[k];
                end
            end
            for (int k = 1; k < PLS_LENGTH; k += 2)
            begin
                if (dpls[PLS_LENGTH-1-k])
                begin
                    pre -= win_re[SOF_LENGTH+k];
                    pim -= win_im[SOF_LENGTH+k];
                end
                else
                begin
                    pre += win_re[SOF_LENGTH+k];
                    pim += win_im[SOF_LENGTH+k];
                end
            end
            r0 = clip(sre + pre);
            i0 = clip(sim + pim);
            r1 = clip(sre - pre);
            i1 = clip(sim - pim);
            m0 = r0 * r0 + i0 * i0;
            m1 = r1 * r1 + i1 * i1;
            if (m0 > m1)
            begin
                e.re = r0; e.im = i0; e.pilots = 1'b0;
            end
            else
            begin
                e.re = r1; e.im = i1; e.pilots = 1'b1;
                m0 = m1;
            end
            e.hit = (m0 > longint'({5'b0, thresh})) && (e.im > 0);
            e.full = (fill >= WIN_LEN);
            pending.push_back(e);
        endfunction

        task check_beat(corr_beat_t got);
            corr_beat_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("output beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            beats_checked++;
            if (e.hit) hits_seen++;
            if (e.pilots) pilots_seen++;
            if (got.re !== e.re) report_mismatch($sformatf("corr_re %0d exp %0d", got.re, e.re));
            if (got.im !== e.im) report_mismatch($sformatf("corr_im %0d exp %0d", got.im, e.im));
            if (got.hit !== e.hit) report_mismatch($sformatf("header_hit %b exp %b", got.hit, e.hit));
            if (got.pilots !== e.pilots)
                report_mismatch($sformatf("pilots_on %b exp %b", got.pilots, e.pilots));
            if (got.full !== e.full)
                report_mismatch($sformatf("window_full %b exp %b", got.full, e.full));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [THRESH_W-1:0]      cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [11:0]       sample_i;
    logic signed [11:0]       sample_q;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [CORR_W-1:0] corr_re;
    logic signed [CORR_W-1:0] corr_im;
    logic                     header_hit;
    logic                     pilots_on;
    logic                     window_full;

    corr_scoreboard sb;
    bit             calm;
    int             hold_off = 0;
    bit             hold_go = 1'b0;
    bit             hold_done = 1'b0;

    dvbs2_plheader_diff_correlator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_i(sample_i), .sample_q(sample_q),
        .out_valid(out_valid), .out_stall(out_stall),
        .corr_re(corr_re), .corr_im(corr_im),
        .header_hit(header_hit), .pilots_on(pilots_on), .window_full(window_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_symbol(logic signed [11:0] si, logic signed [11:0] sq);
        if (!calm)
        begin
            while ($urandom_range(99) < 31)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        sample_i <= si;
        sample_q <= sq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_symbol(si, sq);
    endtask

    task automatic write_threshold(logic [THRESH_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.thresh = value;
    endtask

    task automatic send_header_frame(int amp);
        logic [SOF_LENGTH-1:0] sof;
        logic [PLS_LENGTH-1:0] pls;
        logic [PLS_LENGTH-1:0] code;
        logic                  bitv;
        sof = SOF_WORD;
        pls = PLS_WORD;
        code = {$urandom, $urandom} ^ pls;
        for (int k = 0; k < WIN_LEN; k++)
        begin
            if (k < SOF_LENGTH)
                bitv = sof[SOF_LENGTH-1-k];
            else
                bitv = code[PLS_LENGTH-1-(k-SOF_LENGTH)];
            send_symbol(12'(bitv ? -amp : amp), 12'((k[0] ^ bitv) ? amp : -amp));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat('{corr_re, corr_im, header_hit, pilots_on, window_full});
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_off <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end

    initial
    begin
        int wait_cycles;
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        sample_i = '0;
        sample_q = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_threshold('0);
        send_symbol(12'sh7FF, 12'sh7FF);
        send_symbol(-12'sd2048, -12'sd2048);
        send_symbol(12'sh7FF, -12'sd2048);
        send_symbol(-12'sd2048, 12'sh7FF);
        send_symbol(12'sd0, 12'sd0);
        send_symbol(12'sh555, 12'shAAA);
        send_symbol(12'shAAA, 12'sh555);
        send_symbol(12'sd1, -12'sd1);
        for (int k = 0; k < 12; k++)
            send_symbol($urandom_range(1) ? 12'sh7FF : -12'sd2048,
                        $urandom_range(1) ? 12'sh7FF : -12'sd2048);

        write_threshold({THRESH_W{1'b1}});
        send_header_frame(2047);
        write_threshold(59'd1 << 40);
        send_header_frame(1800);
        hold_go <= 1'b1;
        for (int k = 0; k < 10; k++)
            send_symbol(12'($urandom), 12'($urandom));

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_threshold(59'd0);
                1: write_threshold(THRESH_W'({$urandom, $urandom}));
                2: write_threshold(59'd1 << 50);
                3: write_threshold(59'd1 << 30);
                default: write_threshold({THRESH_W{1'b1}} - 1);
            endcase
            calm = (p == 2);
            for (int f = 0; f < 1; f++)
            begin
                if ($urandom_range(1))
                    send_header_frame($urandom_range(2047, 256));
                for (int k = 0; k < 90; k++)
                    send_symbol(12'($urandom), 12'($urandom));
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        $display("Checked %0d correlation beats, %0d header hits, %0d with pilots chosen.",
                 sb.beats_checked, sb.hits_seen, sb.pilots_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
